>>> src/voronoi_circle_event_assert.svh
// Assertion macros for the circle-event block checker.
`ifndef VORONOI_CIRCLE_EVENT_ASSERT_SVH
`define VORONOI_CIRCLE_EVENT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VCE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define VCE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/vce_pkg.sv
// Shared constants, codes and types of the circle-event block.
`timescale 1ns / 1ps
`default_nettype none
package vce_pkg;

  localparam int XW   = 18;  // site x width
  localparam int YW   = 17;  // site y width
  localparam int TAGW = 16;
  localparam int OW   = 32;  // result coordinate width
  localparam int NW   = 58;  // signed numerator width
  localparam int DW   = 38;  // divisor width
  localparam int QB   = 31;  // quotient bits below the sign
  localparam int SW   = 64;  // squared distance width
  localparam int RB   = 32;  // root width

  localparam logic [1:0] OUT_EVENT   = 2'd0;
  localparam logic [1:0] OUT_MISSING = 2'd1;
  localparam logic [1:0] OUT_DUP     = 2'd2;
  localparam logic [1:0] OUT_DIVERGE = 2'd3;

  localparam logic signed [OW-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [OW-1:0] SAT_MIN = 32'sh8000_0000;

  // Data that rides alongside the arithmetic
  typedef struct packed {
    logic [1:0]      outcome;
    logic [TAGW-1:0] tag;
    logic [XW-1:0]   ax;
    logic [YW-1:0]   ay;
  } side_t;

endpackage
`default_nettype wire

>>> src/vce_ifs.sv
// Valid/ready channel interfaces for the circle-event block.
`timescale 1ns / 1ps
`default_nettype none
interface vce_in_if import vce_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            has_left;
  logic            has_right;
  logic [XW-1:0]   left_x;
  logic [YW-1:0]   left_y;
  logic [XW-1:0]   mid_x;
  logic [YW-1:0]   mid_y;
  logic [XW-1:0]   right_x;
  logic [YW-1:0]   right_y;
  logic [TAGW-1:0] arc_tag;

  modport source (output valid, has_left, has_right, left_x, left_y, mid_x, mid_y,
                  right_x, right_y, arc_tag, input ready);
  modport sink (input valid, has_left, has_right, left_x, left_y, mid_x, mid_y,
                right_x, right_y, arc_tag, output ready);
endinterface

interface vce_out_if import vce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           outcome;
  logic [TAGW-1:0]      tag_out;
  logic signed [OW-1:0] center_x;
  logic signed [OW-1:0] center_y;
  logic signed [OW-1:0] event_y;

  modport source (output valid, outcome, tag_out, center_x, center_y, event_y, input ready);
  modport sink (input valid, outcome, tag_out, center_x, center_y, event_y, output ready);
endinterface
`default_nettype wire

>>> src/vce_div.sv
// Dual-lane pipelined restoring divider with floor rounding and 32-bit saturation.
`timescale 1ns / 1ps
`default_nettype none
module vce_div import vce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  side_t                in_side,
  input  logic signed [NW-1:0] nx,
  input  logic signed [NW-1:0] ny,
  input  logic [DW-1:0]        d2,
  output logic                 out_v,
  output side_t                out_side,
  output logic signed [OW-1:0] qx,
  output logic signed [OW-1:0] qy
);

  localparam int CW = DW + QB;

  logic          v_r   [0:QB];
  side_t         sd_r  [0:QB];
  logic [NW-2:0] rx_r  [0:QB];
  logic [NW-2:0] ry_r  [0:QB];
  logic [QB-1:0] qx_r  [0:QB];
  logic [QB-1:0] qy_r  [0:QB];
  logic [DW-1:0] d_r   [0:QB];
  logic          ngx_r [0:QB];
  logic          ngy_r [0:QB];
  logic          ovx_r [0:QB];
  logic          ovy_r [0:QB];

  logic [NW-2:0] mx_nxt, my_nxt;
  logic          ovx_nxt, ovy_nxt;

  // floor(n/d) for n < 0 is ~floor(~n/d), so divide magnitudes only
  always_comb begin
    mx_nxt  = nx[NW-1] ? ~nx[NW-2:0] : nx[NW-2:0];
    my_nxt  = ny[NW-1] ? ~ny[NW-2:0] : ny[NW-2:0];
    ovx_nxt = CW'(mx_nxt) >= {d2, {QB{1'b0}}};
    ovy_nxt = CW'(my_nxt) >= {d2, {QB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0]  <= in_side;
      rx_r[0]  <= mx_nxt;
      ry_r[0]  <= my_nxt;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      d_r[0]   <= d2;
      ngx_r[0] <= nx[NW-1];
      ngy_r[0] <= ny[NW-1];
      ovx_r[0] <= ovx_nxt;
      ovy_r[0] <= ovy_nxt;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int SH = QB - j;
    logic [CW-1:0] cand;
    logic          gex, gey;
    logic [QB-1:0] qxn, qyn;

    always_comb begin
      cand    = CW'(d_r[j-1]) << SH;
      gex     = CW'(rx_r[j-1]) >= cand;
      gey     = CW'(ry_r[j-1]) >= cand;
      qxn     = qx_r[j-1];
      qyn     = qy_r[j-1];
      qxn[SH] = gex;
      qyn[SH] = gey;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[j]  <= sd_r[j-1];
        rx_r[j]  <= gex ? rx_r[j-1] - cand[NW-2:0] : rx_r[j-1];
        ry_r[j]  <= gey ? ry_r[j-1] - cand[NW-2:0] : ry_r[j-1];
        qx_r[j]  <= qxn;
        qy_r[j]  <= qyn;
        d_r[j]   <= d_r[j-1];
        ngx_r[j] <= ngx_r[j-1];
        ngy_r[j] <= ngy_r[j-1];
        ovx_r[j] <= ovx_r[j-1];
        ovy_r[j] <= ovy_r[j-1];
      end
    end
  end

  logic                 out_v_r;
  side_t                out_side_r;
  logic signed [OW-1:0] qx_r_out, qy_r_out;
  logic signed [OW-1:0] qx_nxt, qy_nxt;

  always_comb begin
    if (ovx_r[QB]) begin
      qx_nxt = ngx_r[QB] ? SAT_MIN : SAT_MAX;
    end else begin
      qx_nxt = ngx_r[QB] ? ~{1'b0, qx_r[QB]} : {1'b0, qx_r[QB]};
    end
    if (ovy_r[QB]) begin
      qy_nxt = ngy_r[QB] ? SAT_MIN : SAT_MAX;
    end else begin
      qy_nxt = ngy_r[QB] ? ~{1'b0, qy_r[QB]} : {1'b0, qy_r[QB]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= sd_r[QB];
      qx_r_out   <= qx_nxt;
      qy_r_out   <= qy_nxt;
    end
  end

  assign out_v    = out_v_r;
  assign out_side = out_side_r;
  assign qx       = qx_r_out;
  assign qy       = qy_r_out;

endmodule
`default_nettype wire

>>> src/vce_sqrt.sv
// Pipelined radius (distance to the left site, rounded root) and event position.
`timescale 1ns / 1ps
`default_nettype none
module vce_sqrt import vce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  side_t                in_side,
  input  logic signed [OW-1:0] cx,
  input  logic signed [OW-1:0] cy,
  output logic                 out_v,
  output side_t                out_side,
  output logic signed [OW-1:0] out_cx,
  output logic signed [OW-1:0] out_cy,
  output logic signed [OW-1:0] event_y
);

  localparam int LO_W = 16;
  localparam int AW   = OW + 1;      // distance magnitude width
  localparam int HI_W = AW - LO_W;

  function automatic logic signed [OW-1:0] sat_ey(input logic signed [OW+2:0] v);
    if (v > (OW+3)'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < (OW+3)'(SAT_MIN)) begin
      return SAT_MIN;
    end else begin
      return v[OW-1:0];
    end
  endfunction

  // Stage A: distance magnitudes
  logic signed [OW+1:0] dx_nxt, dy_nxt, adx_w, ady_w;
  logic                 va_r;
  side_t                sa_r;
  logic signed [OW-1:0] cxa_r, cya_r;
  logic [AW-1:0]        adx_r, ady_r;

  always_comb begin
    dx_nxt = (OW+2)'($signed({1'b0, in_side.ax})) - (OW+2)'(cx);
    dy_nxt = (OW+2)'($signed({1'b0, in_side.ay})) - (OW+2)'(cy);
    adx_w  = dx_nxt[OW+1] ? -dx_nxt : dx_nxt;
    ady_w  = dy_nxt[OW+1] ? -dy_nxt : dy_nxt;
  end

  // Stage B: partial products of the squares
  logic                   vb_r;
  side_t                  sb_r;
  logic signed [OW-1:0]   cxb_r, cyb_r;
  logic [2*HI_W-1:0]      hhx_r, hhy_r;
  logic [HI_W+LO_W-1:0]   hlx_r, hly_r;
  logic [2*LO_W-1:0]      llx_r, lly_r;

  // Stage C: per-axis squares
  logic                   vc_r;
  side_t                  sc_r;
  logic signed [OW-1:0]   cxc_r, cyc_r;
  logic [SW-1:0]          sqx_r, sqy_r;

  // Root stages: index 0 holds the sum, then one result bit per stage
  logic                 v_r    [0:RB];
  side_t                sd_r   [0:RB];
  logic signed [OW-1:0] cxs_r  [0:RB];
  logic signed [OW-1:0] cys_r  [0:RB];
  logic [SW-1:0]        s_r    [0:RB];
  logic [RB+1:0]        rem_r  [0:RB];
  logic [RB-1:0]        root_r [0:RB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      va_r   <= in_v;
      vb_r   <= va_r;
      vc_r   <= vb_r;
      v_r[0] <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r      <= in_side;
      cxa_r     <= cx;
      cya_r     <= cy;
      adx_r     <= adx_w[AW-1:0];
      ady_r     <= ady_w[AW-1:0];

      sb_r      <= sa_r;
      cxb_r     <= cxa_r;
      cyb_r     <= cya_r;
      hhx_r     <= adx_r[AW-1:LO_W] * adx_r[AW-1:LO_W];
      hhy_r     <= ady_r[AW-1:LO_W] * ady_r[AW-1:LO_W];
      hlx_r     <= adx_r[AW-1:LO_W] * adx_r[LO_W-1:0];
      hly_r     <= ady_r[AW-1:LO_W] * ady_r[LO_W-1:0];
      llx_r     <= adx_r[LO_W-1:0] * adx_r[LO_W-1:0];
      lly_r     <= ady_r[LO_W-1:0] * ady_r[LO_W-1:0];

      sc_r      <= sb_r;
      cxc_r     <= cxb_r;
      cyc_r     <= cyb_r;
      sqx_r     <= (SW'(hhx_r) << (2*LO_W)) + (SW'(hlx_r) << (LO_W+1)) + SW'(llx_r);
      sqy_r     <= (SW'(hhy_r) << (2*LO_W)) + (SW'(hly_r) << (LO_W+1)) + SW'(lly_r);

      sd_r[0]   <= sc_r;
      cxs_r[0]  <= cxc_r;
      cys_r[0]  <= cyc_r;
      s_r[0]    <= sqx_r + sqy_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= RB; k++) begin : g_root
    logic [RB+1:0] remsh, trial;
    logic          ge;

    always_comb begin
      remsh = {rem_r[k-1][RB-1:0], s_r[k-1][SW-1 -: 2]};
      trial = {root_r[k-1], 2'b01};
      ge    = remsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[k]   <= sd_r[k-1];
        cxs_r[k]  <= cxs_r[k-1];
        cys_r[k]  <= cys_r[k-1];
        s_r[k]    <= s_r[k-1] << 2;
        rem_r[k]  <= ge ? remsh - trial : remsh;
        root_r[k] <= {root_r[k-1][RB-2:0], ge};
      end
    end
  end

  // Round to nearest: bump the root when the remainder exceeds it
  logic [RB:0]          r1_w;
  logic signed [OW+2:0] ey_sum;
  logic                 out_v_r;
  side_t                out_side_r;
  logic signed [OW-1:0] out_cx_r, out_cy_r, ey_r;

  always_comb begin
    r1_w   = (RB+1)'(root_r[RB]) + (RB+1)'(rem_r[RB] > (RB+2)'(root_r[RB]));
    ey_sum = (OW+3)'(cys_r[RB]) + (OW+3)'($signed({1'b0, r1_w}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= sd_r[RB];
      out_cx_r   <= cxs_r[RB];
      out_cy_r   <= cys_r[RB];
      ey_r       <= sat_ey(ey_sum);
    end
  end

  assign out_v    = out_v_r;
  assign out_side = out_side_r;
  assign out_cx   = out_cx_r;
  assign out_cy   = out_cy_r;
  assign event_y  = ey_r;

endmodule
`default_nettype wire

>>> src/voronoi_circle_event.sv
// Top level of the circle-event test: orientation, circumcenter and event position.
//
// Takes one triple of beach-line sites per clock while the output skid register is empty
// and returns one result beat per triple, in order. The pipe holds the 31-stage restoring
// divider that forms the rounded circumcenter and the 32-stage digit-by-digit square root
// that forms the radius, both behind the P1 to P6 front stages. Outcome priority is missing
// neighbor, then duplicate site, then diverging bisectors (orientation >= 0); for every
// outcome but an event the coordinates read zero. A stall on the result side freezes the
// pipe; a one-beat skid register at the output keeps the input open on the stalling cycle.
`timescale 1ns / 1ps
`default_nettype none
module voronoi_circle_event import vce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vce_in_if.sink    in_bus,
  vce_out_if.source out_bus
);

  localparam int SPLIT = 20;   // low slice of the bisector constants

  logic en;
  logic sk_v_r;

  assign en           = !sk_v_r;
  assign in_bus.ready = en;

  // P1: differences, sums and the early outcomes
  logic                 dup_w;
  side_t                s1_nxt;
  logic                 v1_r;
  side_t                s1_r;
  logic signed [18:0]   a1_r, k1_r;
  logic signed [17:0]   b1_r, l1_r;
  logic [18:0]          sabx1_r, sbcx1_r;
  logic [17:0]          saby1_r, sbcy1_r;

  always_comb begin
    dup_w = (in_bus.left_x == in_bus.mid_x && in_bus.left_y == in_bus.mid_y) ||
            (in_bus.left_x == in_bus.right_x && in_bus.left_y == in_bus.right_y) ||
            (in_bus.mid_x == in_bus.right_x && in_bus.mid_y == in_bus.right_y);
    s1_nxt.tag = in_bus.arc_tag;
    s1_nxt.ax  = in_bus.left_x;
    s1_nxt.ay  = in_bus.left_y;
    if (!(in_bus.has_left && in_bus.has_right)) begin
      s1_nxt.outcome = OUT_MISSING;
    end else if (dup_w) begin
      s1_nxt.outcome = OUT_DUP;
    end else begin
      s1_nxt.outcome = OUT_EVENT;
    end
  end

  // P2: first products
  logic                 v2_r;
  side_t                s2_r;
  logic signed [18:0]   a2_r, k2_r;
  logic signed [17:0]   b2_r, l2_r;
  logic signed [36:0]   pal2_r, pbk2_r, pc22_r, pm22_r;
  logic signed [38:0]   pc12_r, pm12_r;

  // P3: orientation and bisector constants
  logic signed [36:0]   d3_nxt;
  side_t                s3_nxt;
  logic                 v3_r;
  side_t                s3_r;
  logic signed [18:0]   a3_r, k3_r;
  logic signed [17:0]   b3_r, l3_r;
  logic signed [36:0]   d3_r;
  logic signed [38:0]   c23_r, m23_r;

  always_comb begin
    d3_nxt = pal2_r - pbk2_r;
    s3_nxt = s2_r;
    if (s2_r.outcome == OUT_EVENT && !d3_nxt[36]) begin
      s3_nxt.outcome = OUT_DIVERGE;
    end
  end

  // P4: numerator partial products
  logic signed [18:0]   ch_w, mh_w;
  logic signed [20:0]   cl_w, ml_w;
  logic                 v4_r;
  side_t                s4_r;
  logic signed [36:0]   d4_r;
  logic signed [36:0]   lch4_r, bmh4_r;
  logic signed [38:0]   lcl4_r, bml4_r;
  logic signed [37:0]   amh4_r, kch4_r;
  logic signed [39:0]   aml4_r, kcl4_r;

  assign ch_w = c23_r[38:SPLIT];
  assign mh_w = m23_r[38:SPLIT];
  assign cl_w = $signed({1'b0, c23_r[SPLIT-1:0]});
  assign ml_w = $signed({1'b0, m23_r[SPLIT-1:0]});

  // P5: high and low halves of the numerators
  logic                 v5_r;
  side_t                s5_r;
  logic signed [36:0]   d5_r;
  logic signed [38:0]   hx5_r, hy5_r;
  logic signed [40:0]   lx5_r, ly5_r;

  // P6: rounded numerators and doubled divisor
  logic signed [38:0]   d2_w;
  logic                 v6_r;
  side_t                s6_r;
  logic signed [NW-1:0] nx6_r, ny6_r;
  logic [DW-1:0]        dd6_r;

  assign d2_w = -(39'(d5_r) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_bus.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= s1_nxt;
      a1_r    <= $signed({1'b0, in_bus.mid_x}) - $signed({1'b0, in_bus.left_x});
      b1_r    <= $signed({1'b0, in_bus.mid_y}) - $signed({1'b0, in_bus.left_y});
      k1_r    <= $signed({1'b0, in_bus.mid_x}) - $signed({1'b0, in_bus.right_x});
      l1_r    <= $signed({1'b0, in_bus.mid_y}) - $signed({1'b0, in_bus.right_y});
      sabx1_r <= {1'b0, in_bus.left_x} + {1'b0, in_bus.mid_x};
      saby1_r <= {1'b0, in_bus.left_y} + {1'b0, in_bus.mid_y};
      sbcx1_r <= {1'b0, in_bus.mid_x} + {1'b0, in_bus.right_x};
      sbcy1_r <= {1'b0, in_bus.mid_y} + {1'b0, in_bus.right_y};

      s2_r    <= s1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      k2_r    <= k1_r;
      l2_r    <= l1_r;
      pal2_r  <= 37'(a1_r) * 37'(l1_r);
      pbk2_r  <= 37'(b1_r) * 37'(k1_r);
      pc12_r  <= 39'(a1_r) * 39'($signed({1'b0, sabx1_r}));
      pc22_r  <= 37'(b1_r) * 37'($signed({1'b0, saby1_r}));
      pm12_r  <= 39'(k1_r) * 39'($signed({1'b0, sbcx1_r}));
      pm22_r  <= 37'(l1_r) * 37'($signed({1'b0, sbcy1_r}));

      s3_r    <= s3_nxt;
      a3_r    <= a2_r;
      b3_r    <= b2_r;
      k3_r    <= k2_r;
      l3_r    <= l2_r;
      d3_r    <= d3_nxt;
      // squared-length differences, factored as difference times sum
      c23_r   <= -(pc12_r + 39'(pc22_r));
      m23_r   <= -(pm12_r + 39'(pm22_r));

      s4_r    <= s3_r;
      d4_r    <= d3_r;
      lch4_r  <= 37'(l3_r) * 37'(ch_w);
      lcl4_r  <= 39'(l3_r) * 39'(cl_w);
      bmh4_r  <= 37'(b3_r) * 37'(mh_w);
      bml4_r  <= 39'(b3_r) * 39'(ml_w);
      amh4_r  <= 38'(a3_r) * 38'(mh_w);
      aml4_r  <= 40'(a3_r) * 40'(ml_w);
      kch4_r  <= 38'(k3_r) * 38'(ch_w);
      kcl4_r  <= 40'(k3_r) * 40'(cl_w);

      s5_r    <= s4_r;
      d5_r    <= d4_r;
      hx5_r   <= 39'(lch4_r) - 39'(bmh4_r);
      lx5_r   <= 41'(lcl4_r) - 41'(bml4_r);
      hy5_r   <= 39'(amh4_r) - 39'(kch4_r);
      ly5_r   <= 41'(aml4_r) - 41'(kcl4_r);

      // adding den/2 = -d turns round-half-up into a plain floor
      s6_r    <= s5_r;
      nx6_r   <= (NW'(hx5_r) <<< SPLIT) + NW'(lx5_r) - NW'(d5_r);
      ny6_r   <= (NW'(hy5_r) <<< SPLIT) + NW'(ly5_r) - NW'(d5_r);
      dd6_r   <= d2_w[DW-1:0];
    end
  end

  logic                 dv_v;
  side_t                dv_side;
  logic signed [OW-1:0] dv_qx, dv_qy;

  vce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v6_r),
    .in_side  (s6_r),
    .nx       (nx6_r),
    .ny       (ny6_r),
    .d2       (dd6_r),
    .out_v    (dv_v),
    .out_side (dv_side),
    .qx       (dv_qx),
    .qy       (dv_qy)
  );

  logic                 sq_v;
  side_t                sq_side;
  logic signed [OW-1:0] sq_cx, sq_cy, sq_ey;

  vce_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dv_v),
    .in_side  (dv_side),
    .cx       (dv_qx),
    .cy       (dv_qy),
    .out_v    (sq_v),
    .out_side (sq_side),
    .out_cx   (sq_cx),
    .out_cy   (sq_cy),
    .event_y  (sq_ey)
  );

  // Result beat with coordinates cleared when no event is made
  logic                 ev_w;
  logic signed [OW-1:0] cur_cx, cur_cy, cur_ey;
  logic [1:0]           sk_oc_r;
  logic [TAGW-1:0]      sk_tag_r;
  logic signed [OW-1:0] sk_cx_r, sk_cy_r, sk_ey_r;

  always_comb begin
    ev_w   = sq_side.outcome == OUT_EVENT;
    cur_cx = ev_w ? sq_cx : '0;
    cur_cy = ev_w ? sq_cy : '0;
    cur_ey = ev_w ? sq_ey : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (out_bus.ready) begin
        sk_v_r <= 1'b0;
      end
    end else if (sq_v && !out_bus.ready) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v_r) begin
      sk_oc_r  <= sq_side.outcome;
      sk_tag_r <= sq_side.tag;
      sk_cx_r  <= cur_cx;
      sk_cy_r  <= cur_cy;
      sk_ey_r  <= cur_ey;
    end
  end

  assign out_bus.valid    = sk_v_r || sq_v;
  assign out_bus.outcome  = sk_v_r ? sk_oc_r : sq_side.outcome;
  assign out_bus.tag_out  = sk_v_r ? sk_tag_r : sq_side.tag;
  assign out_bus.center_x = sk_v_r ? sk_cx_r : cur_cx;
  assign out_bus.center_y = sk_v_r ? sk_cy_r : cur_cy;
  assign out_bus.event_y  = sk_v_r ? sk_ey_r : cur_ey;

endmodule
`default_nettype wire

>>> src/vce_chk.sv
// Port-level assertion checker for the circle-event block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "voronoi_circle_event_assert.svh"
module vce_chk import vce_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           outcome,
  input logic [TAGW-1:0]      tag_out,
  input logic signed [OW-1:0] center_x,
  input logic signed [OW-1:0] center_y,
  input logic signed [OW-1:0] event_y
);

  `VCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(tag_out) && $stable(center_x) && $stable(center_y) && $stable(event_y), "result beat changed while stalled")

  // a stalled result always parks in the skid, which closes the input
  `VCE_ASSERT_NEXT(a_stall_closes_in, out_valid && !out_ready, !in_ready, "input open behind a held result")

  `VCE_ASSERT(a_no_event_zero, out_valid && outcome != OUT_EVENT, center_x == 0 && center_y == 0 && event_y == 0, "coordinates set without an event")

  `VCE_ASSERT(a_event_below, out_valid && outcome == OUT_EVENT, event_y >= center_y, "event above the circle center")

  `VCE_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result beat right after reset")

endmodule

bind voronoi_circle_event vce_chk u_vce_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .outcome   (out_bus.outcome),
  .tag_out   (out_bus.tag_out),
  .center_x  (out_bus.center_x),
  .center_y  (out_bus.center_y),
  .event_y   (out_bus.event_y)
);
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the circle-event block: directed table plus random triples.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import vce_pkg::*;

  typedef struct {
    logic            has_left;
    logic            has_right;
    logic [XW-1:0]   left_x;
    logic [YW-1:0]   left_y;
    logic [XW-1:0]   mid_x;
    logic [YW-1:0]   mid_y;
    logic [XW-1:0]   right_x;
    logic [YW-1:0]   right_y;
    logic [TAGW-1:0] arc_tag;
  } triple_t;

  typedef struct {
    logic [1:0]           outcome;
    logic [TAGW-1:0]      tag_out;
    logic signed [OW-1:0] center_x;
    logic signed [OW-1:0] center_y;
    logic signed [OW-1:0] event_y;
  } circle_t;

  typedef struct {
    triple_t t;
    bit      known;  // expected result typed into the table
    circle_t res;
  } row_t;

  localparam int NRAND = 750;
  localparam logic [XW-1:0] XMAX = 18'd163840;
  localparam logic [YW-1:0] YMAX = 17'd122880;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vce_in_if  in_bus ();
  vce_out_if out_bus ();

  voronoi_circle_event DUT (.clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus));

  circle_t pending_circles[$];
  int      mismatches = 0;
  int      n_beats = 0;
  int      n_events = 0;
  int      n_diverge = 0;
  int      n_sat = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("voronoi_circle_event regression: fail");
    $finish;
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // nearest, ties toward plus infinity; den > 0
  function automatic longint div_round(longint num, longint den);
    longint n;
    n = num + den / 2;
    if (n >= 0) return n / den;
    return -((-n + den - 1) / den);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic circle_t circle_event(triple_t t);
    circle_t o;
    longint ax, ay, bx, by, cx, cy, a, b, k, l, d, c2, m2, den, nx, ny, ox, oy, dx, dy;
    longint unsigned s, r;
    ax = longint'(t.left_x);  ay = longint'(t.left_y);
    bx = longint'(t.mid_x);   by = longint'(t.mid_y);
    cx = longint'(t.right_x); cy = longint'(t.right_y);
    o.tag_out = t.arc_tag;
    o.center_x = '0;
    o.center_y = '0;
    o.event_y = '0;
    if (!t.has_left || !t.has_right) begin
      o.outcome = OUT_MISSING;
    end else if ((ax == bx && ay == by) || (ax == cx && ay == cy) ||
                 (bx == cx && by == cy)) begin
      o.outcome = OUT_DUP;
    end else begin
      a = bx - ax; b = by - ay;
      k = bx - cx; l = by - cy;
      d = a * l - b * k;
      if (d >= 0) begin
        o.outcome = OUT_DIVERGE;
      end else begin
        o.outcome = OUT_EVENT;
        c2 = ax * ax - bx * bx + ay * ay - by * by;
        m2 = cx * cx - bx * bx + cy * cy - by * by;
        den = -2 * d;
        nx = -(b * m2 - l * c2);
        ny = -(k * c2 - a * m2);
        ox = sat_word(div_round(nx, den));
        oy = sat_word(div_round(ny, den));
        dx = ax - ox;
        dy = ay - oy;
        s = longint'(dx * dx) + longint'(dy * dy);
        r = root_floor(s);
        if (s > r * r + r) r++;
        o.center_x = ox[31:0];
        o.center_y = oy[31:0];
        o.event_y = OW'(sat_word(oy + longint'(r)));
      end
    end
    return o;
  endfunction

  function automatic triple_t mk(bit hl, bit hr, int lx, int ly, int mx, int my,
                                 int rx, int ry, int tag);
    triple_t t;
    t.has_left = hl; t.has_right = hr;
    t.left_x = XW'(lx);  t.left_y = YW'(ly);
    t.mid_x = XW'(mx);   t.mid_y = YW'(my);
    t.right_x = XW'(rx); t.right_y = YW'(ry);
    t.arc_tag = TAGW'(tag);
    return t;
  endfunction

  function automatic circle_t none_res(logic [1:0] oc, int tag);
    circle_t o;
    o.outcome = oc; o.tag_out = TAGW'(tag);
    o.center_x = '0; o.center_y = '0; o.event_y = '0;
    return o;
  endfunction

  // coordinates: mostly near a cluster so circles stay finite, some full range
  function automatic triple_t rand_triple();
    triple_t t;
    int cxv, cyv, sp, mode;
    mode = $urandom_range(0, 9);
    t.has_left = ($urandom_range(0, 15) != 0);
    t.has_right = ($urandom_range(0, 15) != 0);
    t.arc_tag = TAGW'($urandom);
    if (mode < 2) begin
      t.left_x = XW'($urandom_range(0, XMAX));  t.left_y = YW'($urandom_range(0, YMAX));
      t.mid_x = XW'($urandom_range(0, XMAX));   t.mid_y = YW'($urandom_range(0, YMAX));
      t.right_x = XW'($urandom_range(0, XMAX)); t.right_y = YW'($urandom_range(0, YMAX));
    end else begin
      sp = (mode < 5) ? 16 : 4000;
      cxv = $urandom_range(sp, XMAX - sp);
      cyv = $urandom_range(sp, YMAX - sp);
      t.left_x = XW'(cxv + $urandom_range(0, 2 * sp) - sp);
      t.left_y = YW'(cyv + $urandom_range(0, 2 * sp) - sp);
      t.mid_x = XW'(cxv + $urandom_range(0, 2 * sp) - sp);
      t.mid_y = YW'(cyv + $urandom_range(0, 2 * sp) - sp);
      t.right_x = XW'(cxv + $urandom_range(0, 2 * sp) - sp);
      t.right_y = YW'(cyv + $urandom_range(0, 2 * sp) - sp);
      if (mode == 9) begin
        // horizontal or vertical pair, sometimes a repeated site
        if ($urandom_range(0, 1)) t.mid_y = t.left_y;
        else t.right_x = t.mid_x;
        if ($urandom_range(0, 3) == 0) begin
          t.right_x = t.left_x; t.right_y = t.left_y;
        end
      end
    end
    return t;
  endfunction

  // entered and left at a falling edge; valid stays up only for a back-to-back beat
  task automatic send_triple(triple_t t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.has_left <= t.has_left;   in_bus.has_right <= t.has_right;
    in_bus.left_x <= t.left_x;       in_bus.left_y <= t.left_y;
    in_bus.mid_x <= t.mid_x;         in_bus.mid_y <= t.mid_y;
    in_bus.right_x <= t.right_x;     in_bus.right_y <= t.right_y;
    in_bus.arc_tag <= t.arc_tag;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_checked(row_t r);
    circle_t e;
    e = circle_event(r.t);
    if (r.known) e = r.res;
    pending_circles.insert(pending_circles.size(), e);
    send_triple(r.t);
  endtask

  // result side: random stalls, compare each beat with the oldest expectation
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (stall != 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_bus.ready <= 1'b1;
        do @(posedge clk); while (!out_bus.valid);
        n_beats++;
        if (pending_circles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat, tag %h", out_bus.tag_out);
        end else begin
          circle_t e;
          e = pending_circles.pop_front();
          if (e.outcome == OUT_EVENT) n_events++;
          if (e.outcome == OUT_DIVERGE) n_diverge++;
          if (e.center_x == SAT_MAX || e.center_x == SAT_MIN ||
              e.center_y == SAT_MAX || e.center_y == SAT_MIN) n_sat++;
          if (out_bus.outcome !== e.outcome || out_bus.tag_out !== e.tag_out ||
              out_bus.center_x !== e.center_x || out_bus.center_y !== e.center_y ||
              out_bus.event_y !== e.event_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp oc=%0d tag=%h cx=%0d cy=%0d ey=%0d",
                        " | got oc=%0d tag=%h cx=%0d cy=%0d ey=%0d"},
                       e.outcome, e.tag_out, e.center_x, e.center_y, e.event_y,
                       out_bus.outcome, out_bus.tag_out, out_bus.center_x,
                       out_bus.center_y, out_bus.event_y);
          end
        end
      end
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    int waited;
    in_bus.valid = 1'b0;
    in_bus.has_left = 1'b0; in_bus.has_right = 1'b0;
    in_bus.left_x = '0; in_bus.left_y = '0;
    in_bus.mid_x = '0;  in_bus.mid_y = '0;
    in_bus.right_x = '0; in_bus.right_y = '0;
    in_bus.arc_tag = '0;

    r.known = 1'b1;
    r.t = mk(0, 1, 0, 0, 1, 1, 2, 0, 16'h0000);
    r.res = none_res(OUT_MISSING, 16'h0000); dir = {dir, r};
    r.t = mk(1, 0, XMAX, YMAX, 0, 0, 5, 5, 16'hffff);
    r.res = none_res(OUT_MISSING, 16'hffff); dir = {dir, r};
    r.t = mk(0, 0, 3, 3, 3, 3, 3, 3, 16'h5555);
    r.res = none_res(OUT_MISSING, 16'h5555); dir = {dir, r};
    r.t = mk(1, 1, 7, 9, 7, 9, 100, 0, 16'haaaa);
    r.res = none_res(OUT_DUP, 16'haaaa); dir = {dir, r};
    r.t = mk(1, 1, 7, 9, 50, 0, 7, 9, 16'h1234);
    r.res = none_res(OUT_DUP, 16'h1234); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, XMAX, YMAX, XMAX, YMAX, 16'h00ff);
    r.res = none_res(OUT_DUP, 16'h00ff); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, 100, 100, 200, 200, 16'h0f0f);
    r.res = none_res(OUT_DIVERGE, 16'h0f0f); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, 0, YMAX, XMAX, 0, 16'hf0f0);
    r.res = none_res(OUT_DIVERGE, 16'hf0f0); dir = {dir, r};
    r.known = 1'b0;
    // events, horizontal pairs, extremes and near-collinear (saturating) triples
    r.t = mk(1, 1, 0, YMAX, XMAX, YMAX, XMAX, 0, 16'h0001); dir = {dir, r};
    r.t = mk(1, 1, 0, 256, 256, 0, 512, 256, 16'h0002); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, 0, YMAX, XMAX, YMAX, 16'h0003); dir = {dir, r};
    r.t = mk(1, 1, 100, 100, 200, 100, 150, 0, 16'h0004); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, 1, 0, 1, 1, 16'h0005); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, XMAX, 1, XMAX / 2, 0, 16'h0006); dir = {dir, r};
    r.t = mk(1, 1, 0, 0, XMAX, 0, XMAX - 1, 1, 16'h0007); dir = {dir, r};
    r.t = mk(1, 1, 0, YMAX, XMAX, YMAX - 1, XMAX / 2, YMAX, 16'h0008); dir = {dir, r};
    r.t = mk(1, 1, XMAX, 0, 0, YMAX, XMAX, YMAX, 16'h0009); dir = {dir, r};
    r.t = mk(1, 1, 3, 4, 0, 0, 3, 0, 16'h000a); dir = {dir, r};
    r.t = mk(1, 1, 262143, 131071, 0, 0, 262143, 0, 16'h000b); dir = {dir, r};
    r.t = mk(1, 1, 0, 131071, 262143, 131071, 262143, 0, 16'h000c); dir = {dir, r};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir[i]) send_checked(dir[i]);

    r.known = 1'b0;
    for (int i = 0; i < NRAND; i++) begin
      if (i == NRAND / 2) begin
        // drain fully before continuing
        in_bus.valid <= 1'b0;
        @(negedge clk);
        waited = 0;
        while (pending_circles.size() != 0 && waited < 5000) begin
          @(negedge clk);
          waited++;
        end
      end
      r.t = rand_triple();
      send_checked(r);
    end

    in_bus.valid <= 1'b0;
    @(negedge clk);
    waited = 0;
    while (pending_circles.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (100) @(negedge clk);
    $display("ran %0d triples, %0d result beats: %0d circle events, %0d diverging",
             dir.size() + NRAND, n_beats, n_events, n_diverge);
    $display("%0d events had a saturated center", n_sat);
    if (mismatches == 0 && pending_circles.size() == 0) begin
      $display("voronoi_circle_event regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_circles.size());
      $display("voronoi_circle_event regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
